// File: sv/qlod_pkg.sv
// Package: types and constants shared by the offload decider files.
`timescale 1ns / 1ps
package qlod_pkg;

  localparam int unsigned NumBinsDef = 10;

  localparam logic [2:0] CfgLearnRate    = 3'd0;
  localparam logic [2:0] CfgDiscount     = 3'd1;
  localparam logic [2:0] CfgExploreRate  = 3'd2;
  localparam logic [2:0] CfgPenaltyStep  = 3'd3;
  localparam logic [2:0] CfgSmoothFactor = 3'd4;

  localparam logic [15:0] LearnRateRst    = 16'd6554;
  localparam logic [15:0] DiscountRst     = 16'd58982;
  localparam logic [15:0] ExploreRateRst  = 16'd3277;
  localparam logic [15:0] PenaltyStepRst  = 16'd3277;
  localparam logic [15:0] SmoothFactorRst = 16'd655;

  typedef struct packed {
    logic [31:0] local_delay;
    logic [31:0] offload_delay;
    logic [31:0] local_energy;
    logic [31:0] offload_energy;
    logic [15:0] random_draw;
    logic        random_choice;
  } item_t;

  typedef struct packed {
    logic       offload;
    logic       forced_local;
    logic       explored;
    logic [3:0] delay_bin;
    logic [3:0] energy_bin;
  } result_t;

endpackage

// File: sv/q_learning_offload_decider.sv
// Top level: tabular Q-learning offload decider with epsilon-greedy choice.
// Sequence from the accepting edge to the result strobe: two ratio divisions,
//   three table reads, two multiply steps, update, decide, smooth, penalty.
// A new item is taken only when idle; busy stays high until the result strobe.
// Reset: control and configuration registers return to defaults; a clearing pass then
//   zeroes all 2*NUM_BINS^2 Q-table entries, with busy high. Results cannot be stalled.
`timescale 1ns / 1ps
module q_learning_offload_decider #(
  parameter int unsigned NUM_BINS = qlod_pkg::NumBinsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  qlod_pkg::item_t   item_i,
  output logic              result_valid_o,
  output qlod_pkg::result_t result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  localparam int unsigned QSize = 2 * NUM_BINS * NUM_BINS;
  localparam int unsigned AW    = $clog2(QSize);
  localparam int unsigned BW    = $clog2(NUM_BINS);
  // dividends: od*NB < 2^39, oe*2NB < 2^40; quotient kept to 8 bits plus an overflow flag
  localparam int unsigned DivSteps = 8;
  localparam logic [7:0] TopBin = 8'(NUM_BINS - 1);

  // sequencer codes
  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StDivD  = 4'd2;
  localparam logic [3:0] StDivE  = 4'd3;
  localparam logic [3:0] StRd0   = 4'd4;
  localparam logic [3:0] StRd1   = 4'd5;
  localparam logic [3:0] StRdP   = 4'd6;
  localparam logic [3:0] StMul   = 4'd7;
  localparam logic [3:0] StUpd   = 4'd8;
  localparam logic [3:0] StDec   = 4'd9;
  localparam logic [3:0] StSm    = 4'd10;
  localparam logic [3:0] StPen   = 4'd11;
  localparam logic [3:0] StOut   = 4'd12;
  localparam logic [3:0] StRdP2  = 4'd13;

  // multiplier job codes
  localparam logic [2:0] MReward = 3'd0;
  localparam logic [2:0] MDisc   = 3'd1;

  logic [3:0]  st_q, st_d;
  logic [15:0] lr_q, df_q, er_q, ps_q, sf_q;
  qlod_pkg::item_t it_q;
  logic [BW-1:0] pdb_q, peb_q;
  logic        pact_q, pval_q;
  logic [31:0] pw_q, sd_q;
  logic [BW-1:0] db_q, eb_q;
  logic [AW-1:0] clr_q;

  // shared restoring divider: first step flags a quotient of 2^DivSteps or more,
  // then DivSteps steps give the quotient bits MSB first
  logic [47:0] num_q;
  logic [47:0] den_q;
  logic [5:0]  dcnt_q;
  logic [7:0]  quo_q;
  logic        ovf_q;

  // table access
  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata, rdata;
  logic signed [31:0] q0_q, q1_q, qp_q;

  // serial multiplier: 50-bit signed operand times 16-bit unsigned fraction
  logic [2:0]  mjob_q;
  logic signed [65:0] acc_q;
  logic        act_q, forced_q, expl_q;
  logic        rv_q;
  qlod_pkg::result_t res_q;

  qlod_ram #(.Width(32), .Depth(QSize)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  function automatic logic [AW-1:0] qidx(logic [BW-1:0] d, logic [BW-1:0] e, logic a);
    logic [AW+BW:0] i;
    i = ((AW+BW+1)'(d) * (AW+BW+1)'(NUM_BINS) + (AW+BW+1)'(e)) * (AW+BW+1)'(2) +
        (AW+BW+1)'(a);
    return AW'(i);
  endfunction

  // floor(a*b/2^16) for signed a (|a| < 2^49), unsigned 16-bit b
  function automatic logic signed [65:0] mulf(logic signed [49:0] a, logic [15:0] b);
    logic signed [66:0] p;
    p = 67'(a) * $signed({51'd0, b});
    return 66'(p >>> 16);
  endfunction

  function automatic logic signed [49:0] sat32(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 50'sd2147483647;
    if (v < -66'sd2147483648) return -50'sd2147483648;
    return 50'(v);
  endfunction

  assign busy        = (st_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign result_valid_o = rv_q;
  assign result_o    = res_q;

  logic signed [32:0] viol;
  logic [48:0] trial;
  assign viol  = pact_q ? ($signed({1'b0, it_q.offload_delay}) -
                           $signed({1'b0, it_q.local_delay})) : 33'sd0;
  assign trial = {1'b0, num_q} - {1'b0, den_q};

  always_comb begin
    we    = 1'b0;
    addr  = qidx(db_q, eb_q, 1'b0);
    wdata = 32'd0;
    case (st_q)
      StClear: begin we = 1'b1; addr = clr_q; end
      StRd0:   addr = qidx(db_q, eb_q, 1'b0);
      StRd1:   addr = qidx(db_q, eb_q, 1'b1);
      StRdP:   addr = qidx(pdb_q, peb_q, pact_q);
      StUpd:   begin
        addr  = qidx(pdb_q, peb_q, pact_q);
        we    = pval_q;
        wdata = 32'(sat32(66'(qp_q) + acc_q));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; clr_q <= '0;
      lr_q <= qlod_pkg::LearnRateRst; df_q <= qlod_pkg::DiscountRst;
      er_q <= qlod_pkg::ExploreRateRst; ps_q <= qlod_pkg::PenaltyStepRst;
      sf_q <= qlod_pkg::SmoothFactorRst;
      pdb_q <= '0; peb_q <= '0; pact_q <= 1'b0; pval_q <= 1'b0;
      pw_q <= '0; sd_q <= '0; rv_q <= 1'b0; dcnt_q <= '0; mjob_q <= MReward;
    end else begin
      rv_q <= (st_q == StOut);
      if (cfg_valid_i) begin
        case (cfg_index_i)
          qlod_pkg::CfgLearnRate:    lr_q <= cfg_data_i;
          qlod_pkg::CfgDiscount:     df_q <= cfg_data_i;
          qlod_pkg::CfgExploreRate:  er_q <= cfg_data_i;
          qlod_pkg::CfgPenaltyStep:  ps_q <= cfg_data_i;
          qlod_pkg::CfgSmoothFactor: sf_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (st_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(QSize - 1)) st_q <= StIdle;
        end
        StIdle: if (start) begin
          it_q <= item_i;
          // delay: od*NB / (2*ld); divisor starts scaled by 2^DivSteps
          num_q <= 48'(64'(item_i.offload_delay) * NUM_BINS);
          den_q <= 48'({item_i.local_delay, 1'b0}) << DivSteps;
          ovf_q <= 1'b0;
          quo_q <= '0; dcnt_q <= '0; st_q <= StDivD;
        end
        StDivD, StDivE: begin
          // restoring division: one overflow check, then one quotient bit per cycle
          if (dcnt_q == 6'(DivSteps + 1)) begin
            if (st_q == StDivD) begin
              db_q  <= BW'((ovf_q || quo_q > TopBin) ? TopBin : quo_q);
              num_q <= 48'(64'(it_q.offload_energy) * (2 * NUM_BINS));
              den_q <= 48'(it_q.local_energy) << DivSteps;
              ovf_q <= 1'b0;
              quo_q <= '0; dcnt_q <= '0; st_q <= StDivE;
            end else begin
              eb_q <= BW'((ovf_q || quo_q > TopBin) ? TopBin : quo_q);
              st_q <= StRd0;
            end
          end else begin
            dcnt_q <= dcnt_q + 1'b1;
            den_q  <= den_q >> 1;
            if (dcnt_q == 6'd0) begin
              // quotient too large for the bins, or a zero divisor: top bin
              ovf_q <= !trial[48];
            end else if (!trial[48]) begin
              num_q <= trial[47:0];
              quo_q <= {quo_q[6:0], 1'b1};
            end else begin
              quo_q <= {quo_q[6:0], 1'b0};
            end
          end
        end
        StRd0: st_q <= StRd1;
        StRd1: begin q0_q <= $signed(rdata); st_q <= StRdP; end
        StRdP: begin q1_q <= $signed(rdata); st_q <= StRdP2; end
        StRdP2: begin
          qp_q <= $signed(rdata);
          // split the penalty weight: low half floored, high half exact
          acc_q <= mulf(50'(viol), pw_q[15:0]) +
                   66'(viol) * $signed({1'b0, pw_q[31:16]});
          mjob_q <= MReward; st_q <= StMul;
        end
        StMul: begin
          case (mjob_q)
            MReward: begin
              acc_q <= 66'(sat32(-66'(pact_q ? {1'b0, it_q.offload_energy}
                                             : {1'b0, it_q.local_energy}) - acc_q))
                       + mulf(50'((q1_q > q0_q) ? q1_q : q0_q), df_q) - 66'(qp_q);
              mjob_q <= MDisc;
            end
            MDisc: begin
              acc_q <= mulf(50'(acc_q), lr_q);
              st_q  <= StUpd;
            end
            default: st_q <= StUpd;
          endcase
        end
        StUpd: begin
          if (pval_q && qidx(pdb_q, peb_q, pact_q) == qidx(db_q, eb_q, 1'b0))
            q0_q <= $signed(wdata);
          if (pval_q && qidx(pdb_q, peb_q, pact_q) == qidx(db_q, eb_q, 1'b1))
            q1_q <= $signed(wdata);
          st_q <= StDec;
        end
        StDec: begin
          if (34'(it_q.offload_delay) * 2 > 34'(it_q.local_delay) * 3) begin
            act_q <= 1'b0; forced_q <= 1'b1; expl_q <= 1'b0;
          end else if (it_q.random_draw < er_q) begin
            act_q <= it_q.random_choice; forced_q <= 1'b0; expl_q <= 1'b1;
          end else begin
            act_q <= (q1_q > q0_q); forced_q <= 1'b0; expl_q <= 1'b0;
          end
          st_q <= StSm;
        end
        StSm: begin
          acc_q <= 66'((49'(17'd65536 - 17'(sf_q)) * sd_q +
                   49'(sf_q) * (act_q ? it_q.offload_delay : it_q.local_delay)) >> 16);
          st_q <= StPen;
        end
        StPen: begin
          sd_q <= 32'(acc_q);
          begin
            logic signed [65:0] lam;
            lam = 66'(pw_q) + mulf(50'($signed({1'b0, acc_q[31:0]}) -
                                     $signed({1'b0, it_q.local_delay})), ps_q);
            if (lam < 0) pw_q <= 32'd0;
            else if (lam > 66'sh0FFFFFFFF) pw_q <= 32'hFFFFFFFF;
            else pw_q <= 32'(lam);
          end
          st_q <= StOut;
        end
        StOut: begin
          pdb_q <= db_q; peb_q <= eb_q; pact_q <= act_q; pval_q <= 1'b1;
          res_q.offload <= act_q; res_q.forced_local <= forced_q;
          res_q.explored <= expl_q;
          res_q.delay_bin <= 4'(db_q); res_q.energy_bin <= 4'(eb_q);
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

// File: sv/qlod_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module qlod_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 200
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
